// File: src/rtiu_pkg.sv
// ----------------------------------------------------------------------------
// rtiu_pkg: shared types and constants of the integer execute unit
// operation codes, field widths and the widths of the item packing
// ----------------------------------------------------------------------------
package rtiu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned CMD_W = 5;
	localparam int unsigned SH_W = 5;
	localparam int unsigned IN_W = 112;  // 106 bits of fields, padded to bytes
	localparam int unsigned OUT_W = 72;  // 67 bits of fields, padded to bytes
	localparam int unsigned CNT_W = 6;

	typedef enum logic [CMD_W-1:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MULT = 5'd2, OP_DIV = 5'd3,
		OP_JAL = 5'd4, OP_JR = 5'd5, OP_MFHI = 5'd6, OP_MFLO = 5'd7,
		OP_MTHI = 5'd8, OP_MTLO = 5'd9, OP_XOR = 5'd10, OP_NOR = 5'd11,
		OP_OR = 5'd12, OP_AND = 5'd13, OP_SLL = 5'd14, OP_SLLV = 5'd15,
		OP_SRL = 5'd16, OP_SRLV = 5'd17, OP_SRA = 5'd18, OP_SRAV = 5'd19,
		OP_SLT = 5'd20, OP_SLTU = 5'd21
	} op_t;

endpackage

// File: src/register_type_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// register_type_integer_execute_unit: integer alu with hi/lo multiply, divide
// one item in, one result item out; mult and div run on a shared shift and add/subtract unit
// ----------------------------------------------------------------------------
// flow: other ops are captured in ST_IDLE, computed and registered in ST_EXEC, shown in ST_OUT
// mult and div also pass through ST_ITER: one shared 33-bit add/subtract per bit, 32 steps
// a div with a zero divisor skips ST_ITER and goes from ST_EXEC to ST_OUT like the other ops
// throughput: one item at a time; s_axis_tready is low while an item is in work
// or its result waits on m_axis
// arst_n clears control state and hi/lo to zero
module register_type_integer_execute_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// command, operand_s, operand_t, shift_amount, current_pc, zero pad
	input  logic [rtiu_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// result_value, writes_destination, jump_taken, jump_target, divide_by_zero, pad
	output logic [rtiu_pkg::OUT_W-1:0]   m_axis_tdata
);
	import rtiu_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_ITER, ST_OUT} state_t;

	state_t               state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [XLEN-1:0]      s_q, t_q, pc_q;
	logic [SH_W-1:0]      sa_q;
	logic [XLEN-1:0]      hi_q, lo_q;
	logic [XLEN-1:0]      acc_q;      // partial remainder / high product
	logic [XLEN-1:0]      wrk_q;      // dividend-quotient / multiplier-low product
	logic [XLEN-1:0]      dsr_q;      // magnitude of divisor or multiplicand
	logic                 neg_q, rneg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [XLEN-1:0]      res_q, tgt_q;
	logic                 wr_q, jmp_q, dz_q;

	logic                 is_mult;
	logic [XLEN:0]        sum;
	logic [XLEN-1:0]      s_abs, t_abs, sres;
	logic [SH_W-1:0]      shamt;
	logic                 wr_c, jmp_c;
	logic [XLEN-1:0]      res_c;
	logic [2*XLEN-1:0]    prod, prod_n;
	logic [XLEN-1:0]      quo, rem;

	assign is_mult = (cmd_q == OP_MULT);
	assign s_abs = s_q[XLEN-1] ? (~s_q + 1'b1) : s_q;
	assign t_abs = t_q[XLEN-1] ? (~t_q + 1'b1) : t_q;
	assign shamt = (cmd_q == OP_SLL || cmd_q == OP_SRL || cmd_q == OP_SRA) ? sa_q : s_q[SH_W-1:0];
	assign sres = $unsigned($signed(t_q) >>> shamt);

	// the one shared adder: add for multiply, trial subtract for divide
	always_comb begin
		if (is_mult)
			sum = {1'b0, acc_q} + {1'b0, (wrk_q[0] ? dsr_q : {XLEN{1'b0}})};
		else
			sum = {1'b0, acc_q[XLEN-2:0], wrk_q[XLEN-1]} - {1'b0, dsr_q}
				+ ({acc_q[XLEN-1], {XLEN{1'b0}}});
	end

	always_comb begin
		res_c = '0;
		wr_c = 1'b1;
		jmp_c = 1'b0;
		case (cmd_q)
			OP_ADD:  res_c = s_q + t_q;
			OP_SUB:  res_c = s_q - t_q;
			OP_JAL:  begin res_c = pc_q + 32'd4; jmp_c = 1'b1; end
			OP_JR:   begin wr_c = 1'b0; jmp_c = 1'b1; end
			OP_MFHI: res_c = hi_q;
			OP_MFLO: res_c = lo_q;
			OP_XOR:  res_c = s_q ^ t_q;
			OP_NOR:  res_c = ~(s_q | t_q);
			OP_OR:   res_c = s_q | t_q;
			OP_AND:  res_c = s_q & t_q;
			OP_SLL, OP_SLLV: res_c = t_q << shamt;
			OP_SRL, OP_SRLV: res_c = t_q >> shamt;
			OP_SRA, OP_SRAV: res_c = sres;
			OP_SLT:  res_c = {31'd0, $signed(s_q) < $signed(t_q)};
			OP_SLTU: res_c = {31'd0, s_q < t_q};
			default: wr_c = 1'b0;
		endcase
	end

	assign prod = {acc_q, wrk_q};
	assign prod_n = neg_q ? (~prod + 1'b1) : prod;
	assign quo = neg_q ? (~wrk_q + 1'b1) : wrk_q;
	assign rem = rneg_q ? (~acc_q + 1'b1) : acc_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {5'd0, dz_q, tgt_q, jmp_q, wr_q, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hi_q <= '0;
			lo_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= s_axis_tdata[4:0];
						s_q <= s_axis_tdata[36:5];
						t_q <= s_axis_tdata[68:37];
						sa_q <= s_axis_tdata[73:69];
						pc_q <= s_axis_tdata[105:74];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_q <= '0;
					wr_q <= 1'b0;
					jmp_q <= 1'b0;
					tgt_q <= '0;
					dz_q <= 1'b0;
					acc_q <= '0;
					wrk_q <= s_abs;
					dsr_q <= t_abs;
					neg_q <= s_q[XLEN-1] ^ t_q[XLEN-1];
					rneg_q <= s_q[XLEN-1];
					cnt_q <= '0;
					state_q <= ST_OUT;
					if (cmd_q == OP_MULT) begin
						state_q <= ST_ITER;
					end else if (cmd_q == OP_DIV) begin
						if (t_q == '0) dz_q <= 1'b1;
						else state_q <= ST_ITER;
					end else if (cmd_q == OP_MTHI) begin
						hi_q <= s_q;
					end else if (cmd_q == OP_MTLO) begin
						lo_q <= s_q;
					end else begin
						res_q <= wr_c ? res_c : '0;
						wr_q <= wr_c;
						jmp_q <= jmp_c;
						tgt_q <= jmp_c ? s_q : '0;
					end
				end
				ST_ITER: begin
					if (cnt_q == CNT_W'(XLEN)) begin
						if (is_mult) begin
							hi_q <= prod_n[2*XLEN-1:XLEN];
							lo_q <= prod_n[XLEN-1:0];
						end else begin
							lo_q <= quo;
							hi_q <= rem;
						end
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (is_mult) begin
							{acc_q, wrk_q} <= {sum, wrk_q[XLEN-1:1]};
						end else if (!sum[XLEN]) begin
							acc_q <= sum[XLEN-1:0];
							wrk_q <= {wrk_q[XLEN-2:0], 1'b1};
						end else begin
							acc_q <= {acc_q[XLEN-2:0], wrk_q[XLEN-1]};
							wrk_q <= {wrk_q[XLEN-2:0], 1'b0};
						end
					end
				end
				ST_OUT: begin
					if (m_axis_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
	a_dz_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && dz_q |-> cmd_q == OP_DIV) else $error("dz on non-div");
	a_hi_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |=> $stable(hi_q) && $stable(lo_q)) else $error("hi/lo changed idle");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER |-> cnt_q <= CNT_W'(XLEN)) else $error("count overrun");
`endif

endmodule

// File: dv/rtiu_checker.sv
// ----------------------------------------------------------------------------
// rtiu_checker: result checker of the integer execute unit
// watches both streams, predicts each result from its item and compares it
// ----------------------------------------------------------------------------
module rtiu_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [rtiu_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [rtiu_pkg::OUT_W-1:0] m_axis_tdata,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rtiu_pkg::*;

	typedef struct packed {
		logic        divide_by_zero;
		logic [31:0] jump_target;
		logic        jump_taken;
		logic        writes_destination;
		logic [31:0] result_value;
	} alu_result_t;

	logic [31:0] hi_q, lo_q;
	alu_result_t result_fifo[$];

	initial fail_count = 0;
	assign pending = result_fifo.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		fail_count++;
	endtask

	function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] sh);
		return $unsigned($signed(v) >>> sh);
	endfunction

	// updates hi/lo and returns the expected result of one item
	function automatic alu_result_t execute(input logic [IN_W-1:0] d);
		logic [4:0] cmd;
		logic [31:0] s, t, pc;
		logic [4:0] sa;
		logic signed [63:0] prod, a, b;
		alu_result_t r;
		cmd = d[4:0];
		s = d[36:5];
		t = d[68:37];
		sa = d[73:69];
		pc = d[105:74];
		r = '0;
		r.writes_destination = 1'b1;
		case (cmd)
			OP_ADD: r.result_value = s + t;
			OP_SUB: r.result_value = s - t;
			OP_MULT: begin
				prod = $signed({{32{s[31]}}, s}) * $signed({{32{t[31]}}, t});
				hi_q = prod[63:32];
				lo_q = prod[31:0];
				r.writes_destination = 1'b0;
			end
			OP_DIV: begin
				r.writes_destination = 1'b0;
				if (t == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					a = $signed({{32{s[31]}}, s});
					b = $signed({{32{t[31]}}, t});
					lo_q = 32'(a / b);
					hi_q = 32'(a % b);
				end
			end
			OP_JAL: begin
				r.result_value = pc + 32'd4;
				r.jump_taken = 1'b1;
				r.jump_target = s;
			end
			OP_JR: begin
				r.writes_destination = 1'b0;
				r.jump_taken = 1'b1;
				r.jump_target = s;
			end
			OP_MFHI: r.result_value = hi_q;
			OP_MFLO: r.result_value = lo_q;
			OP_MTHI: begin
				hi_q = s;
				r.writes_destination = 1'b0;
			end
			OP_MTLO: begin
				lo_q = s;
				r.writes_destination = 1'b0;
			end
			OP_XOR: r.result_value = s ^ t;
			OP_NOR: r.result_value = ~(s | t);
			OP_OR: r.result_value = s | t;
			OP_AND: r.result_value = s & t;
			OP_SLL: r.result_value = t << sa;
			OP_SLLV: r.result_value = t << s[4:0];
			OP_SRL: r.result_value = t >> sa;
			OP_SRLV: r.result_value = t >> s[4:0];
			OP_SRA: r.result_value = sra32(t, sa);
			OP_SRAV: r.result_value = sra32(t, s[4:0]);
			OP_SLT: r.result_value = {31'd0, $signed(s) < $signed(t)};
			OP_SLTU: r.result_value = {31'd0, s < t};
			default: r = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_result_t got, want;
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_fifo.push_back(execute(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[66:0];
				if (result_fifo.size() == 0) begin
					$display("unexpected result item %h", got);
					fail_count++;
				end else begin
					want = result_fifo.pop_front();
					if (got.result_value !== want.result_value)
						report("result_value", got.result_value, want.result_value);
					if (got.writes_destination !== want.writes_destination)
						report("writes_destination", got.writes_destination,
							want.writes_destination);
					if (got.jump_taken !== want.jump_taken)
						report("jump_taken", got.jump_taken, want.jump_taken);
					if (got.jump_target !== want.jump_target)
						report("jump_target", got.jump_target, want.jump_target);
					if (got.divide_by_zero !== want.divide_by_zero)
						report("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
				end
			end
		end
	end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the integer execute unit
// directed corner items, then random instruction streams under varying stalls
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rtiu_pkg::*;

	localparam int WATCHDOG = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	int fail_count, pending;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	register_type_integer_execute_unit i_dut (.*);

	rtiu_checker i_checker (.*);

	function automatic logic [IN_W-1:0] pack_item(input logic [4:0] cmd, input logic [31:0] s,
			input logic [31:0] t, input logic [4:0] sa, input logic [31:0] pc);
		return {6'd0, pc, sa, t, s, cmd};
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	// tvalid stays high into the next item; idle cycles and stop_sending drop it
	task automatic send(input logic [IN_W-1:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		logic [4:0] cmd;
		cmd = ($urandom_range(0, 29) == 0) ? 5'($urandom_range(22, 31)) : 5'($urandom_range(0, 21));
		send(pack_item(cmd, rand_word(), rand_word(), 5'($urandom), $urandom));
	endtask

	// receiver stalls; a long hold-off overrides the random pattern
	always @(posedge clk)
		m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: every operation and the corner cases
		for (int op = 0; op < 22; op++)
			send(pack_item(5'(op), 32'h80000001, 32'hfffffff5, 5'd31, 32'hfffffffe));
		send(pack_item(OP_MULT, 32'h80000000, 32'h80000000, 5'd0, 32'd0));
		send(pack_item(OP_MFHI, 32'd0, 32'd0, 5'd0, 32'd0));
		send(pack_item(OP_DIV, 32'h80000000, 32'hffffffff, 5'd0, 32'd0));
		send(pack_item(OP_MFLO, 32'd0, 32'd0, 5'd0, 32'd0));
		send(pack_item(OP_DIV, 32'd7, 32'd0, 5'd0, 32'd0));
		send(pack_item(OP_MFHI, 32'd0, 32'd0, 5'd0, 32'd0));
		send(pack_item(OP_DIV, -32'sd7, 32'd2, 5'd0, 32'd0));
		send(pack_item(OP_MFHI, 32'd0, 32'd0, 5'd0, 32'd0));
		send(pack_item(5'd31, 32'hffffffff, 32'hffffffff, 5'd31, 32'hffffffff));
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 62 : 23) : 0;
			recv_stall_pct = (ph == 2) ? 62 : ((ph == 3) ? 23 : 0);
			for (int n = 0; n < 440; n++) send_random();
			// pause the sender until everything has drained
			stop_sending();
			while (pending != 0) @(posedge clk);
			if (ph == 1) begin
				// long receiver hold-off while the sender keeps offering
				hold_off = 1'b1;
				fork
					begin repeat (300) @(posedge clk); hold_off = 1'b0; end
					begin
						for (int n = 0; n < 8; n++) send_random();
						stop_sending();
					end
				join
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
